// ===== rtl/core/erfc_pkg.sv =====
// ----------------------------------------------------------------------------
// erfc_pkg
// Shared types and constants of the receive frame classifier: frame offsets,
// ethertypes, verdict codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package erfc_pkg;

  // Frame length limit and counter sizing
  localparam int unsigned MAX_FRAME_BYTES = 2047;
  localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LEN_W           = 11;

  // Joined multicast group slots that take part in filtering
  localparam int unsigned GROUP_SLOTS = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_BASE = 3'd1;

  // Header byte offsets
  localparam int unsigned POS_ETYPE      = 12;
  localparam int unsigned POS_HDR        = 14;
  localparam int unsigned POS_PROTO      = 16;
  localparam int unsigned POS_ARP_ALEN   = 18;
  localparam int unsigned POS_FRAG       = 20;
  localparam int unsigned POS_MAC_FIRST  = 22;
  localparam int unsigned POS_IP_PROTO   = 23;
  localparam int unsigned POS_MAC_LAST   = 27;
  localparam int unsigned POS_SIP_FIRST  = 28;
  localparam int unsigned POS_SIP_LAST   = 31;
  localparam int unsigned POS_IPD_FIRST  = 30;
  localparam int unsigned POS_IPD_LAST   = 33;
  localparam int unsigned POS_ATIP_FIRST = 38;
  localparam int unsigned POS_ATIP_LAST  = 41;

  // Minimum lengths
  localparam int unsigned MIN_ETH_LEN = 14;
  localparam int unsigned MIN_ARP_LEN = 42;
  localparam int unsigned MIN_IP_LEN  = 34;

  // Protocol constants
  localparam logic [15:0] ETYPE_ARP     = 16'h0806;
  localparam logic [15:0] ETYPE_IP      = 16'h0800;
  localparam logic [15:0] ARP_HW_ETH    = 16'h0001;
  localparam logic [15:0] ARP_ALEN_IP   = 16'h0604;
  localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;
  localparam logic [7:0]  IP_VER_MASK   = 8'hF0;
  localparam logic [7:0]  IP_VER_4      = 8'h40;
  localparam logic [15:0] IP_FRAG_MASK  = 16'h1FFF;
  localparam logic [16:0] CSUM_OK       = 17'h0FFFF;
  localparam logic [31:0] IP_BCAST      = 32'hFFFF_FFFF;
  localparam logic [31:0] IP_ALL_HOSTS  = 32'hE000_0001;
  localparam logic [3:0]  IP_MCAST_NIB  = 4'hE;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_IGMP    = 8'd2;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  typedef enum logic [3:0] {
    V_RUNT        = 4'd0,
    V_ARP_BAD     = 4'd1,
    V_ARP_NOT_US  = 4'd2,
    V_ARP_REQ     = 4'd3,
    V_ARP_REPLY   = 4'd4,
    V_ARP_BAD_OP  = 4'd5,
    V_IP_BAD      = 4'd6,
    V_IP_NOT_US   = 4'd7,
    V_ICMP        = 4'd8,
    V_IGMP        = 4'd9,
    V_UDP         = 4'd10,
    V_OTHER_IP    = 4'd11,
    V_OTHER_ETYPE = 4'd12
  } verdict_e;

endpackage

`default_nettype wire

// ===== rtl/core/ethernet_rx_frame_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// ethernet_rx_frame_classifier_unit
// Byte-wide receive filter: captures Ethernet/ARP/IPv4 header fields as the
// frame streams in and issues one verdict beat when the last byte arrives.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o  | frame_byte_i, last_byte_i
//  out     | out_valid_o / out_stall_i| verdict_o, frame_length_o, ip_dest_o,
//          |                          | arp_sender_ip_o, arp_sender_mac_o
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One byte is taken every cycle while no last byte is held back. Each
//  byte updates the capture registers; the last byte's verdict is formed
//  in the same cycle and lands in the result register, shown in the next cycle.
//  Reset clears all capture state and the configuration registers.
//  Only a last byte is held back, and only while a result sits stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_rx_frame_classifier_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // byte input
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [7:0]                        frame_byte_i,
  input  wire logic                              last_byte_i,
  // verdict output
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [3:0]                        verdict_o,
  output      logic [erfc_pkg::LEN_W-1:0]        frame_length_o,
  output      logic [31:0]                       ip_dest_o,
  output      logic [31:0]                       arp_sender_ip_o,
  output      logic [47:0]                       arp_sender_mac_o,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [erfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [erfc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned CW = erfc_pkg::CNT_W;

  // Configuration registers
  logic [31:0] own_ip_q;
  logic [31:0] group_addr_q [erfc_pkg::GROUP_SLOTS];

  // Capture state
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   etype_q, etype_d;
  logic [15:0]   hwver_q, hwver_d;
  logic [15:0]   ptlen_q, ptlen_d;
  logic [15:0]   alfrag_q, alfrag_d;
  logic [15:0]   opcode_q, opcode_d;
  logic [7:0]    ipproto_q, ipproto_d;
  logic [47:0]   smac_q, smac_d;
  logic [31:0]   sip_q, sip_d;
  logic [31:0]   dip_q, dip_d;
  logic [16:0]   hsum_q, hsum_d;

  // Result register
  logic                       out_valid_q;
  erfc_pkg::verdict_e         verdict_q;
  logic [erfc_pkg::LEN_W-1:0] len_q;
  logic [31:0]                dest_q, osip_q;
  logic [47:0]                osmac_q;

  logic       in_acc;
  logic       is_arp;
  logic [15:0] csum_word;
  logic [17:0] csum_raw;

  erfc_pkg::verdict_e verdict_d;
  logic [31:0]        dest_d, osip_d;
  logic [47:0]        osmac_d;
  logic               mcast, grp_hit;
  logic [16:0]        ip_len_need;

  // Hold a last byte only while the result register is full and stalled
  assign in_stall_o  = out_valid_q & out_stall_i & last_byte_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Capture header fields for the byte at the current offset
  always_comb begin
    cnt_d     = cnt_q;
    etype_d   = etype_q;
    hwver_d   = hwver_q;
    ptlen_d   = ptlen_q;
    alfrag_d  = alfrag_q;
    opcode_d  = opcode_q;
    ipproto_d = ipproto_q;
    smac_d    = smac_q;
    sip_d     = sip_q;
    dip_d     = dip_q;
    hsum_d    = hsum_q;
    is_arp    = (etype_q == erfc_pkg::ETYPE_ARP);
    csum_word = cnt_q[0] ? {8'h00, frame_byte_i} : {frame_byte_i, 8'h00};
    csum_raw  = {1'b0, hsum_q} + {2'b00, csum_word};
    if (cnt_q < CW'(erfc_pkg::MAX_FRAME_BYTES)) begin
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(erfc_pkg::POS_ETYPE) || cnt_q == CW'(erfc_pkg::POS_ETYPE + 1)) begin
        etype_d = {etype_q[7:0], frame_byte_i};
      end
      if (cnt_q == CW'(erfc_pkg::POS_HDR) || cnt_q == CW'(erfc_pkg::POS_HDR + 1)) begin
        hwver_d = {hwver_q[7:0], frame_byte_i};
      end
      if (cnt_q == CW'(erfc_pkg::POS_PROTO) || cnt_q == CW'(erfc_pkg::POS_PROTO + 1)) begin
        ptlen_d = {ptlen_q[7:0], frame_byte_i};
      end
      if (is_arp ? (cnt_q == CW'(erfc_pkg::POS_ARP_ALEN) ||
                    cnt_q == CW'(erfc_pkg::POS_ARP_ALEN + 1))
                 : (cnt_q == CW'(erfc_pkg::POS_FRAG) ||
                    cnt_q == CW'(erfc_pkg::POS_FRAG + 1))) begin
        alfrag_d = {alfrag_q[7:0], frame_byte_i};
      end
      if (is_arp && (cnt_q == CW'(erfc_pkg::POS_FRAG) ||
                     cnt_q == CW'(erfc_pkg::POS_FRAG + 1))) begin
        opcode_d = {opcode_q[7:0], frame_byte_i};
      end
      if (cnt_q == CW'(erfc_pkg::POS_IP_PROTO)) begin
        ipproto_d = frame_byte_i;
      end
      if (cnt_q >= CW'(erfc_pkg::POS_MAC_FIRST) && cnt_q <= CW'(erfc_pkg::POS_MAC_LAST)) begin
        smac_d = {smac_q[39:0], frame_byte_i};
      end
      if (cnt_q >= CW'(erfc_pkg::POS_SIP_FIRST) && cnt_q <= CW'(erfc_pkg::POS_SIP_LAST)) begin
        sip_d = {sip_q[23:0], frame_byte_i};
      end
      if (is_arp ? (cnt_q >= CW'(erfc_pkg::POS_ATIP_FIRST) &&
                    cnt_q <= CW'(erfc_pkg::POS_ATIP_LAST))
                 : (cnt_q >= CW'(erfc_pkg::POS_IPD_FIRST) &&
                    cnt_q <= CW'(erfc_pkg::POS_IPD_LAST))) begin
        dip_d = {dip_q[23:0], frame_byte_i};
      end
      // fold the end-around carry straight back in
      if (cnt_q >= CW'(erfc_pkg::POS_HDR) && cnt_q <= CW'(erfc_pkg::POS_IPD_LAST)) begin
        hsum_d = {1'b0, csum_raw[15:0]} + {15'd0, csum_raw[17:16]};
      end
    end
  end

  // Match the destination against the joined groups
  always_comb begin
    grp_hit = (dip_d == erfc_pkg::IP_ALL_HOSTS);
    for (int g = 0; g < int'(erfc_pkg::GROUP_SLOTS); g++) begin
      if (group_addr_q[g] != 32'd0 && group_addr_q[g] == dip_d) begin
        grp_hit = 1'b1;
      end
    end
  end

  assign mcast       = (dip_d[31:28] == erfc_pkg::IP_MCAST_NIB);
  assign ip_len_need = {1'b0, ptlen_d} + 17'(erfc_pkg::MIN_ETH_LEN);

  // Form the verdict from the fields as they stand after this byte
  always_comb begin
    dest_d  = 32'd0;
    osip_d  = 32'd0;
    osmac_d = 48'd0;
    if (cnt_d < CW'(erfc_pkg::MIN_ETH_LEN)) begin
      verdict_d = erfc_pkg::V_RUNT;
    end else if (etype_d == erfc_pkg::ETYPE_ARP) begin
      dest_d  = dip_d;
      osip_d  = sip_d;
      osmac_d = smac_d;
      priority if (cnt_d < CW'(erfc_pkg::MIN_ARP_LEN) || hwver_d != erfc_pkg::ARP_HW_ETH ||
                   ptlen_d != erfc_pkg::ETYPE_IP || alfrag_d != erfc_pkg::ARP_ALEN_IP) begin
        verdict_d = erfc_pkg::V_ARP_BAD;
      end else if (own_ip_q == 32'd0 || dip_d != own_ip_q) begin
        verdict_d = erfc_pkg::V_ARP_NOT_US;
      end else if (opcode_d == erfc_pkg::ARP_OP_REQ) begin
        verdict_d = erfc_pkg::V_ARP_REQ;
      end else if (opcode_d == erfc_pkg::ARP_OP_REPLY) begin
        verdict_d = erfc_pkg::V_ARP_REPLY;
      end else begin
        verdict_d = erfc_pkg::V_ARP_BAD_OP;
      end
    end else if (etype_d == erfc_pkg::ETYPE_IP) begin
      dest_d = dip_d;
      priority if (cnt_d < CW'(erfc_pkg::MIN_IP_LEN) || 17'(cnt_d) < ip_len_need ||
                   (hwver_d[15:8] & erfc_pkg::IP_VER_MASK) != erfc_pkg::IP_VER_4 ||
                   (alfrag_d & erfc_pkg::IP_FRAG_MASK) != 16'd0 ||
                   hsum_d != erfc_pkg::CSUM_OK) begin
        verdict_d = erfc_pkg::V_IP_BAD;
      end else if ((own_ip_q != 32'd0 && dip_d != own_ip_q && dip_d != erfc_pkg::IP_BCAST &&
                    !mcast) || (mcast && !grp_hit)) begin
        verdict_d = erfc_pkg::V_IP_NOT_US;
      end else if (ipproto_d == erfc_pkg::PROTO_ICMP) begin
        verdict_d = erfc_pkg::V_ICMP;
      end else if (ipproto_d == erfc_pkg::PROTO_IGMP) begin
        verdict_d = erfc_pkg::V_IGMP;
      end else if (ipproto_d == erfc_pkg::PROTO_UDP) begin
        verdict_d = erfc_pkg::V_UDP;
      end else begin
        verdict_d = erfc_pkg::V_OTHER_IP;
      end
    end else begin
      verdict_d = erfc_pkg::V_OTHER_ETYPE;
    end
  end

  // Write configuration registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= 32'd0;
      for (int g = 0; g < int'(erfc_pkg::GROUP_SLOTS); g++) begin
        group_addr_q[g] <= 32'd0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == erfc_pkg::CFG_OWN_IP) begin
        own_ip_q <= cfg_data_i;
      end
      for (int g = 0; g < int'(erfc_pkg::GROUP_SLOTS); g++) begin
        if (cfg_index_i == erfc_pkg::CFG_GROUP_BASE + erfc_pkg::CFG_IDX_W'(g)) begin
          group_addr_q[g] <= cfg_data_i;
        end
      end
    end
  end

  // Advance capture state per beat; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      etype_q   <= '0;
      hwver_q   <= '0;
      ptlen_q   <= '0;
      alfrag_q  <= '0;
      opcode_q  <= '0;
      ipproto_q <= '0;
      smac_q    <= '0;
      sip_q     <= '0;
      dip_q     <= '0;
      hsum_q    <= '0;
    end else if (in_acc) begin
      if (last_byte_i) begin
        cnt_q     <= '0;
        etype_q   <= '0;
        hwver_q   <= '0;
        ptlen_q   <= '0;
        alfrag_q  <= '0;
        opcode_q  <= '0;
        ipproto_q <= '0;
        smac_q    <= '0;
        sip_q     <= '0;
        dip_q     <= '0;
        hsum_q    <= '0;
      end else begin
        cnt_q     <= cnt_d;
        etype_q   <= etype_d;
        hwver_q   <= hwver_d;
        ptlen_q   <= ptlen_d;
        alfrag_q  <= alfrag_d;
        opcode_q  <= opcode_d;
        ipproto_q <= ipproto_d;
        smac_q    <= smac_d;
        sip_q     <= sip_d;
        dip_q     <= dip_d;
        hsum_q    <= hsum_d;
      end
    end
  end

  // Result valid: set by a last byte, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      verdict_q <= verdict_d;
      len_q     <= erfc_pkg::LEN_W'(cnt_d);
      dest_q    <= dest_d;
      osip_q    <= osip_d;
      osmac_q   <= osmac_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign frame_length_o   = len_q;
  assign ip_dest_o        = dest_q;
  assign arp_sender_ip_o  = osip_q;
  assign arp_sender_mac_o = osmac_q;

  // Checks
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> cnt_q == '0)
    else $error("capture counter not cleared after last byte");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(erfc_pkg::MAX_FRAME_BYTES))
    else $error("byte counter past frame limit");

  a_runt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((verdict_q == erfc_pkg::V_RUNT) ==
                     (len_q < erfc_pkg::LEN_W'(erfc_pkg::MIN_ETH_LEN))))
    else $error("runt verdict disagrees with frame length");

  a_sender_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q != erfc_pkg::V_ARP_BAD && verdict_q != erfc_pkg::V_ARP_NOT_US &&
    verdict_q != erfc_pkg::V_ARP_REQ && verdict_q != erfc_pkg::V_ARP_REPLY &&
    verdict_q != erfc_pkg::V_ARP_BAD_OP |-> osip_q == 32'd0 && osmac_q == 48'd0)
    else $error("sender fields set on a non-ARP verdict");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && !(in_acc && last_byte_i) |=> out_valid_q)
    else $error("stalled result lost");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the receive frame classifier. Streams directed
// and random Ethernet frames (ARP, IPv4, runts, truncated, noise, other
// ethertypes) byte by byte under random source gaps and sink stalls,
// predicts each verdict beat in step with the accepted bytes, and checks
// every result field against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import erfc_pkg::*;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned FRAME_BUF_SZ = 2100;
  localparam int unsigned PHASE_BEATS  = 430;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned HOLD_FIRST   = 500;
  localparam int unsigned HOLD_SECOND  = 1300;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } rx_beat_t;

  typedef struct {
    verdict_e    verdict;
    logic [10:0] length;
    logic [31:0] dest_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
  } frame_verdict_t;

  logic clk_i;
  logic rst_ni;

  logic                  in_valid   = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            frame_byte = '0;
  logic                  last_byte  = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall  = 1'b0;
  logic [3:0]            verdict_o;
  logic [LEN_W-1:0]      frame_length_o;
  logic [31:0]           ip_dest_o;
  logic [31:0]           arp_sender_ip_o;
  logic [47:0]           arp_sender_mac_o;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  ethernet_rx_frame_classifier_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .frame_byte_i     (frame_byte),
    .last_byte_i      (last_byte),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .verdict_o        (verdict_o),
    .frame_length_o   (frame_length_o),
    .ip_dest_o        (ip_dest_o),
    .arp_sender_ip_o  (arp_sender_ip_o),
    .arp_sender_mac_o (arp_sender_mac_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // Filter settings as last written
  logic [31:0] cfg_own_ip = '0;
  logic [31:0] cfg_group [GROUP_SLOTS];

  // Header capture state of the frame in flight
  int unsigned pos_cnt       = 0;
  logic [15:0] cap_etype     = '0;
  logic [15:0] cap_hw_ver    = '0;
  logic [15:0] cap_proto_len = '0;
  logic [15:0] cap_alen_frag = '0;
  logic [15:0] cap_opcode    = '0;
  logic [7:0]  cap_ipproto   = '0;
  logic [47:0] cap_smac      = '0;
  logic [31:0] cap_sip       = '0;
  logic [31:0] cap_dip       = '0;
  logic [15:0] cap_hsum      = '0;

  rx_beat_t       beats_pending [$];
  frame_verdict_t verdicts_due [$];
  int unsigned    beats_accepted = 0;
  int unsigned    mismatch_count = 0;

  // Frame under construction
  logic [7:0]  frame_buf [FRAME_BUF_SZ];
  int unsigned frame_len = 0;

  initial begin
    for (int i = 0; i < GROUP_SLOTS; i++) cfg_group[i] = '0;
  end

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Absolute run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Verdict prediction: advance header capture by one byte, and on the last
  // byte classify the frame and clear the capture state.
  // --------------------------------------------------------------------------
  function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                       output frame_verdict_t res);
    bit          was_arp;
    bit          mcast;
    bit          joined;
    logic [16:0] acc;
    int unsigned len;
    was_arp        = (cap_etype == ETYPE_ARP);
    res.verdict    = V_RUNT;
    res.length     = '0;
    res.dest_ip    = '0;
    res.sender_ip  = '0;
    res.sender_mac = '0;

    // Shift the byte into whichever field owns this offset
    if (pos_cnt < MAX_FRAME_BYTES) begin
      if (pos_cnt == POS_ETYPE || pos_cnt == POS_ETYPE + 1)
        cap_etype = {cap_etype[7:0], b};
      if (pos_cnt == POS_HDR || pos_cnt == POS_HDR + 1)
        cap_hw_ver = {cap_hw_ver[7:0], b};
      if (pos_cnt == POS_PROTO || pos_cnt == POS_PROTO + 1)
        cap_proto_len = {cap_proto_len[7:0], b};
      if (was_arp ? (pos_cnt == POS_ARP_ALEN || pos_cnt == POS_ARP_ALEN + 1)
                  : (pos_cnt == POS_FRAG || pos_cnt == POS_FRAG + 1))
        cap_alen_frag = {cap_alen_frag[7:0], b};
      if (was_arp && (pos_cnt == POS_FRAG || pos_cnt == POS_FRAG + 1))
        cap_opcode = {cap_opcode[7:0], b};
      if (pos_cnt == POS_IP_PROTO)
        cap_ipproto = b;
      if (pos_cnt >= POS_MAC_FIRST && pos_cnt <= POS_MAC_LAST)
        cap_smac = {cap_smac[39:0], b};
      if (pos_cnt >= POS_SIP_FIRST && pos_cnt <= POS_SIP_LAST)
        cap_sip = {cap_sip[23:0], b};
      if (was_arp ? (pos_cnt >= POS_ATIP_FIRST && pos_cnt <= POS_ATIP_LAST)
                  : (pos_cnt >= POS_IPD_FIRST && pos_cnt <= POS_IPD_LAST))
        cap_dip = {cap_dip[23:0], b};
      // Folded ones-complement sum over the IPv4 header bytes
      if (pos_cnt >= POS_HDR && pos_cnt <= POS_IPD_LAST) begin
        acc      = cap_hsum + (pos_cnt[0] ? {8'd0, b} : {b, 8'd0});
        cap_hsum = acc[15:0] + acc[16];
      end
      pos_cnt++;
    end
    if (!last) return 1'b0;

    len        = pos_cnt;
    res.length = len[10:0];
    if (len < MIN_ETH_LEN) begin
      res.verdict = V_RUNT;
    end else if (cap_etype == ETYPE_ARP) begin
      res.dest_ip    = cap_dip;
      res.sender_ip  = cap_sip;
      res.sender_mac = cap_smac;
      if (len < MIN_ARP_LEN || cap_hw_ver != ARP_HW_ETH || cap_proto_len != ETYPE_IP ||
          cap_alen_frag != ARP_ALEN_IP)
        res.verdict = V_ARP_BAD;
      else if (cfg_own_ip == '0 || cap_dip != cfg_own_ip)
        res.verdict = V_ARP_NOT_US;
      else if (cap_opcode == ARP_OP_REQ)
        res.verdict = V_ARP_REQ;
      else if (cap_opcode == ARP_OP_REPLY)
        res.verdict = V_ARP_REPLY;
      else
        res.verdict = V_ARP_BAD_OP;
    end else if (cap_etype == ETYPE_IP) begin
      res.dest_ip = cap_dip;
      mcast       = (cap_dip[31:28] == IP_MCAST_NIB);
      joined      = (cap_dip == IP_ALL_HOSTS);
      for (int i = 0; i < GROUP_SLOTS; i++)
        if (cfg_group[i] != '0 && cfg_group[i] == cap_dip) joined = 1'b1;
      if (len < MIN_IP_LEN || len < MIN_ETH_LEN + cap_proto_len)
        res.verdict = V_IP_BAD;
      else if ((cap_hw_ver[15:8] & IP_VER_MASK) != IP_VER_4)
        res.verdict = V_IP_BAD;
      else if ((cap_alen_frag & IP_FRAG_MASK) != '0)
        res.verdict = V_IP_BAD;
      else if ({1'b0, cap_hsum} != CSUM_OK)
        res.verdict = V_IP_BAD;
      else if (mcast ? !joined
                     : (cfg_own_ip != '0 && cap_dip != cfg_own_ip && cap_dip != IP_BCAST))
        res.verdict = V_IP_NOT_US;
      else begin
        case (cap_ipproto)
          PROTO_ICMP: res.verdict = V_ICMP;
          PROTO_IGMP: res.verdict = V_IGMP;
          PROTO_UDP:  res.verdict = V_UDP;
          default:    res.verdict = V_OTHER_IP;
        endcase
      end
    end else begin
      res.verdict = V_OTHER_ETYPE;
    end

    // Start the next frame from scratch
    pos_cnt       = 0;
    cap_etype     = '0;
    cap_hw_ver    = '0;
    cap_proto_len = '0;
    cap_alen_frag = '0;
    cap_opcode    = '0;
    cap_ipproto   = '0;
    cap_smac      = '0;
    cap_sip       = '0;
    cap_dip       = '0;
    cap_hsum      = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Byte driver: bursts of beats with random gaps, each beat held until taken
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : byte_driver
    frame_verdict_t res;
    rx_beat_t       beat;
    logic           nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid;
      // Retire the accepted beat into the predictor
      if (in_valid && !in_stall_o) begin
        if (classify_byte(frame_byte, last_byte, res)) verdicts_due.push_back(res);
        beats_accepted <= beats_accepted + 1;
        nxt_valid = 1'b0;
      end
      // Offer the next beat unless a gap is running
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (beats_pending.size() != 0) begin
          beat       = beats_pending.pop_front();
          frame_byte <= beat.data;
          last_byte  <= beat.last;
          nxt_valid  = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Long sink hold-off: twice during the run, stall the output for a long
  // stretch while bytes keep coming, so the block backs up its input
  // --------------------------------------------------------------------------
  int unsigned long_hold_left = 0;
  int unsigned holds_done     = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_left != 0) begin
        long_hold_left <= long_hold_left - 1;
      end else if ((holds_done == 0 && beats_accepted >= HOLD_FIRST) ||
                   (holds_done == 1 && beats_accepted >= HOLD_SECOND)) begin
        long_hold_left <= HOLD_CYCLES;
        holds_done     <= holds_done + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Verdict monitor: compare each accepted beat with the oldest prediction,
  // and drive the sink stall pattern
  // --------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_run  = 0;

  always @(posedge clk_i) begin : verdict_monitor
    frame_verdict_t want;
    logic           nxt_stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict beat: expected none, got verdict %0d",
                   $time, verdict_o);
          mismatch_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (verdict_o !== want.verdict) begin
            $display("%0t: verdict: expected %0d, got %0d", $time, want.verdict, verdict_o);
            mismatch_count++;
          end
          if (frame_length_o !== want.length) begin
            $display("%0t: frame_length: expected %0d, got %0d", $time, want.length,
                     frame_length_o);
            mismatch_count++;
          end
          if (ip_dest_o !== want.dest_ip) begin
            $display("%0t: ip_dest: expected %h, got %h", $time, want.dest_ip, ip_dest_o);
            mismatch_count++;
          end
          if (arp_sender_ip_o !== want.sender_ip) begin
            $display("%0t: arp_sender_ip: expected %h, got %h", $time, want.sender_ip,
                     arp_sender_ip_o);
            mismatch_count++;
          end
          if (arp_sender_mac_o !== want.sender_mac) begin
            $display("%0t: arp_sender_mac: expected %h, got %h", $time, want.sender_mac,
                     arp_sender_mac_o);
            mismatch_count++;
          end
        end
      end

      // Switch between free-flowing, light, heavy and toggling stall
      if (stall_run == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_run  <= $urandom_range(8, 80);
      end else begin
        stall_run <= stall_run - 1;
      end
      case (stall_mode)
        0:       nxt_stall = 1'b0;
        1:       nxt_stall = ($urandom_range(0, 3) == 0);
        2:       nxt_stall = ($urandom_range(0, 3) != 0);
        default: nxt_stall = ~out_stall;
      endcase
      out_stall <= (long_hold_left != 0) || nxt_stall;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes and frame builders
  // --------------------------------------------------------------------------
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_OWN_IP)
      cfg_own_ip = val;
    else if (idx >= CFG_GROUP_BASE && idx < CFG_GROUP_BASE + GROUP_SLOTS)
      cfg_group[idx - CFG_GROUP_BASE] = val;
  endtask

  task automatic program_filter(input logic [31:0] own, input logic [31:0] g0,
                                input logic [31:0] g1, input logic [31:0] g2,
                                input logic [31:0] g3);
    reg_write(CFG_OWN_IP, own);
    reg_write(CFG_GROUP_BASE, g0);
    reg_write(CFG_GROUP_BASE + 1, g1);
    reg_write(CFG_GROUP_BASE + 2, g2);
    reg_write(CFG_GROUP_BASE + 3, g3);
  endtask

  function automatic logic [31:0] rand_group();
    logic [31:0] w;
    w = $urandom;
    return {IP_MCAST_NIB, w[27:0]};
  endfunction

  // Wait until every byte is taken and every verdict has come back
  task automatic wait_drained();
    while (beats_pending.size() != 0 || in_valid || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_byte(input logic [7:0] b);
    frame_buf[frame_len] = b;
    frame_len++;
  endtask

  // Append n bytes of v, most significant first
  task automatic put_bytes(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) put_byte(v[8*i +: 8]);
  endtask

  task automatic pad_frame(input int unsigned target);
    while (frame_len < target) put_byte($urandom_range(0, 255));
  endtask

  task automatic start_frame(input logic [15:0] etype);
    frame_len = 0;
    if ($urandom_range(0, 3) == 0) put_bytes(48'hFFFF_FFFF_FFFF, 6);
    else put_bytes({$urandom, $urandom}, 6);
    put_bytes({$urandom, $urandom}, 6);
    put_bytes(etype, 2);
  endtask

  // Queue the first n bytes of the frame, marking the final one
  task automatic send_frame(input int unsigned n);
    rx_beat_t beat;
    for (int unsigned i = 0; i < n; i++) begin
      beat.data = frame_buf[i];
      beat.last = (i == n - 1);
      beats_pending.push_back(beat);
    end
  endtask

  // IPv4 header with valid checksum, optionally with one header fault
  task automatic build_ipv4(input bit clean);
    int          fault;
    int          pay;
    int          nib;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [7:0]  ver;
    logic [15:0] tot;
    logic [15:0] flags;
    logic [15:0] csum;
    logic [16:0] acc;
    fault = clean ? 0 : $urandom_range(1, 4);
    case ($urandom_range(0, 5))
      0:       dst = (cfg_own_ip != '0) ? cfg_own_ip : $urandom;
      1:       dst = IP_BCAST;
      2:       dst = IP_ALL_HOSTS;
      3:       dst = cfg_group[$urandom_range(0, GROUP_SLOTS - 1)];
      4:       dst = rand_group();
      default: dst = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0:       proto = PROTO_ICMP;
      1:       proto = PROTO_IGMP;
      2:       proto = PROTO_UDP;
      default: proto = $urandom_range(0, 255);
    endcase
    pay = $urandom_range(0, 30);
    tot = 20 + pay;
    // Version 4 with any IHL, or a wrong version
    nib = $urandom_range(0, 14);
    if (nib >= 4) nib++;
    ver = {(fault == 1) ? 4'(nib) : 4'h4, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h5};
    flags = {3'($urandom), 13'd0};
    if (fault == 2) flags[12:0] = $urandom_range(1, 13'h1FFF);
    if (fault == 3) tot = tot + $urandom_range(1, 40);

    start_frame(ETYPE_IP);
    put_bytes(ver, 1);
    put_bytes($urandom, 1);
    put_bytes(tot, 2);
    put_bytes($urandom, 2);
    put_bytes(flags, 2);
    put_bytes($urandom, 1);
    put_bytes(proto, 1);
    put_bytes(16'd0, 2);
    put_bytes($urandom, 4);
    put_bytes(dst, 4);

    // Fill in the header checksum, or a corrupted one
    acc = '0;
    for (int i = POS_HDR; i <= POS_IPD_LAST; i += 2) begin
      acc = {1'b0, acc[15:0]} + {frame_buf[i], frame_buf[i+1]};
      acc = acc[15:0] + acc[16];
    end
    csum = ~acc[15:0];
    if (fault == 4) csum = csum ^ (16'd1 << $urandom_range(0, 15));
    frame_buf[POS_HDR + 10] = csum[15:8];
    frame_buf[POS_HDR + 11] = csum[7:0];
    for (int i = 0; i < pay; i++) put_byte($urandom_range(0, 255));
  endtask

  // ARP packet, optionally with one header fault
  task automatic build_arp(input bit clean);
    int          fault;
    logic [15:0] opcode;
    fault = clean ? 0 : $urandom_range(1, 3);
    case ($urandom_range(0, 3))
      0, 1:    opcode = ARP_OP_REQ;
      2:       opcode = ARP_OP_REPLY;
      default: opcode = $urandom_range(0, 16'hFFFF);
    endcase
    start_frame(ETYPE_ARP);
    put_bytes((fault == 1) ? 16'($urandom) : ARP_HW_ETH, 2);
    put_bytes((fault == 2) ? 16'($urandom) : ETYPE_IP, 2);
    put_bytes((fault == 3) ? 16'($urandom) : ARP_ALEN_IP, 2);
    put_bytes(opcode, 2);
    put_bytes({$urandom, $urandom}, 6);
    put_bytes($urandom, 4);
    put_bytes({$urandom, $urandom}, 6);
    if (cfg_own_ip != '0 && $urandom_range(0, 3) != 0) put_bytes(cfg_own_ip, 4);
    else put_bytes($urandom, 4);
  endtask

  // Mostly well-formed frames with random content; the rest runts,
  // truncated headers, foreign ethertypes and noise
  task automatic random_frames(input int unsigned n_beats);
    int unsigned queued;
    int unsigned kind;
    queued = 0;
    while (queued < n_beats) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        if (kind < 30) build_ipv4(kind >= 8);
        else build_arp(kind >= 37);
        case ($urandom_range(0, 2))
          0:       ;
          1:       pad_frame(60);
          default: pad_frame(frame_len + $urandom_range(1, 10));
        endcase
        send_frame(frame_len);
        queued += frame_len;
      end else if (kind < 63) begin
        start_frame($urandom_range(0, 16'hFFFF));
        pad_frame(frame_len + $urandom_range(0, 50));
        send_frame(frame_len);
        queued += frame_len;
      end else if (kind < 71) begin
        frame_len = 0;
        pad_frame($urandom_range(1, MIN_ETH_LEN - 1));
        send_frame(frame_len);
        queued += frame_len;
      end else if (kind < 85) begin
        // Cut a good frame short somewhere past the ethertype
        if (kind[0]) build_ipv4(1'b1);
        else build_arp(1'b1);
        kind = $urandom_range(MIN_ETH_LEN, frame_len - 1);
        send_frame(kind);
        queued += kind;
      end else begin
        start_frame(kind[0] ? ETYPE_IP : ETYPE_ARP);
        pad_frame(frame_len + $urandom_range(0, 60));
        send_frame(frame_len);
        queued += frame_len;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] w;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-byte frames of all zeros and all ones, a short runt,
    // and a minimal frame of all ones with an unknown ethertype
    frame_len = 0;
    put_byte(8'h00);
    send_frame(frame_len);
    frame_len = 0;
    put_byte(8'hFF);
    send_frame(frame_len);
    frame_len = 0;
    for (int i = 0; i < 8; i++) put_byte(i[0] ? 8'hAA : 8'h55);
    send_frame(frame_len);
    frame_len = 0;
    for (int i = 0; i < MIN_ETH_LEN; i++) put_byte(8'hFF);
    send_frame(frame_len);
    wait_drained();

    // Private unicast address, two random groups, one empty slot, top group
    w = $urandom;
    program_filter({8'd10, w[23:0]}, rand_group(), rand_group(), 32'd0, 32'hEFFF_FFFF);
    random_frames(PHASE_BEATS);
    wait_drained();

    // All-ones address, odd group entries, and writes to unused indexes
    program_filter(IP_BCAST, IP_ALL_HOSTS, 32'hE000_0000, IP_BCAST, rand_group());
    for (int i = 0; i < 3; i++) reg_write(CFG_GROUP_BASE + GROUP_SLOTS + i, $urandom);
    random_frames(PHASE_BEATS);
    wait_drained();

    // Lowest non-zero address, a single group
    program_filter(32'd1, 32'd0, 32'd0, 32'd0, rand_group());
    random_frames(PHASE_BEATS);
    wait_drained();

    // Unconfigured address, every slot in use
    program_filter(32'd0, rand_group(), rand_group(), rand_group(), rand_group());
    random_frames(PHASE_BEATS);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
